[src/interrupt_dispatch_controller_unit_defines.svh]
// Assertion macros shared by the interrupt dispatch controller.
`ifndef INTERRUPT_DISPATCH_CONTROLLER_UNIT_DEFINES_SVH
`define INTERRUPT_DISPATCH_CONTROLLER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/idc_pkg.sv]
`timescale 1ns / 1ps

package idc_pkg;

   localparam int NUM_SOURCES    = 5;
   localparam int KIND_W         = 3;
   localparam int ADDR_W         = 16;
   localparam int BYTE_W         = 8;
   localparam int VEC_W          = 7;
   localparam int STEP_W         = 3;

   localparam logic [STEP_W-1:0] DISPATCH_STEPS = 3'd5;
   localparam logic [STEP_W-1:0] STEP_DEC_SP    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_PUSH_HIGH = 3'd2;
   localparam logic [STEP_W-1:0] STEP_PUSH_LOW  = 3'd1;

   localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REQUEST    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WR_ENABLE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_WR_FLAGS   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WR_MASTER  = 3'd4;

   localparam logic [VEC_W-1:0] VECTOR_TABLE [NUM_SOURCES] =
      '{7'h40, 7'h48, 7'h50, 7'h58, 7'h60};

   typedef logic [NUM_SOURCES-1:0] src_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      src_type           value;
      logic [ADDR_W-1:0] cur_pc;
      logic [ADDR_W-1:0] cur_sp;
   } req_type;

   typedef struct packed {
      logic              mem_write;
      logic [ADDR_W-1:0] mem_addr;
      logic [BYTE_W-1:0] mem_data;
      logic [ADDR_W-1:0] new_sp;
      logic              pc_load;
      logic [VEC_W-1:0]  new_pc;
      logic              halt_clear;
      logic              ime_out;
      src_type           flags_out;
      logic              busy_res;
   } rsp_type;

   typedef struct packed {
      src_type           request_flags;
      src_type           enable_mask;
      logic              master_enable;
      src_type           active_source;
      logic [STEP_W-1:0] steps_left;
   } state_type;

   // The lowest set bit wins.
   function automatic logic [VEC_W-1:0] vector_of(input src_type src);
      logic [VEC_W-1:0] vec;
      vec = '0;
      for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
         if (src[i]) begin
            vec = VECTOR_TABLE[i];
         end
      end
      return vec;
   endfunction

   function automatic src_type lowest_bit(input src_type bits);
      return bits & (~bits + src_type'(1));
   endfunction

endpackage

[src/idc_req_if.sv]
`timescale 1ns / 1ps

interface idc_req_if
   import idc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   src_type           value;
   logic [ADDR_W-1:0] cur_pc;
   logic [ADDR_W-1:0] cur_sp;

   modport source (output valid, kind, value, cur_pc, cur_sp, input ready);
   modport sink   (input valid, kind, value, cur_pc, cur_sp, output ready);
endinterface

[src/idc_rsp_if.sv]
`timescale 1ns / 1ps

interface idc_rsp_if
   import idc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              mem_write;
   logic [ADDR_W-1:0] mem_addr;
   logic [BYTE_W-1:0] mem_data;
   logic [ADDR_W-1:0] new_sp;
   logic              pc_load;
   logic [VEC_W-1:0]  new_pc;
   logic              halt_clear;
   logic              ime_out;
   src_type           flags_out;
   logic              busy_res;

   modport source (output valid, mem_write, mem_addr, mem_data, new_sp, pc_load,
                    new_pc, halt_clear, ime_out, flags_out, busy_res, input ready);
   modport sink   (input valid, mem_write, mem_addr, mem_data, new_sp, pc_load,
                    new_pc, halt_clear, ime_out, flags_out, busy_res, output ready);
endinterface

[src/idc_step.sv]
`timescale 1ns / 1ps

module idc_step
   import idc_pkg::*;
(
   input  state_type cur_state,
   input  req_type   item,
   output state_type next_state,
   output rsp_type   result
);

   src_type pick;

   assign pick = lowest_bit(cur_state.request_flags & cur_state.enable_mask);

   always_comb begin
      next_state        = cur_state;
      result            = '0;
      result.new_sp     = item.cur_sp;

      unique case (item.kind)
         KIND_TICK: begin
            if (cur_state.steps_left == '0) begin
               if (pick != '0) begin
                  if (!cur_state.master_enable) begin
                     result.halt_clear = 1'b1;
                  end else begin
                     next_state.active_source = pick;
                     next_state.steps_left    = DISPATCH_STEPS;
                  end
               end
            end else begin
               next_state.steps_left = cur_state.steps_left - STEP_W'(1);
               if (cur_state.steps_left == STEP_DEC_SP) begin
                  result.new_sp = item.cur_sp - ADDR_W'(1);
               end else if (cur_state.steps_left == STEP_PUSH_HIGH) begin
                  result.mem_write = 1'b1;
                  result.mem_addr  = item.cur_sp;
                  result.mem_data  = item.cur_pc[ADDR_W-1:BYTE_W];
                  result.new_sp    = item.cur_sp - ADDR_W'(1);
                  if ((cur_state.active_source & cur_state.enable_mask) == '0) begin
                     next_state.active_source = pick;
                  end
               end else if (cur_state.steps_left == STEP_PUSH_LOW) begin
                  result.mem_write          = 1'b1;
                  result.mem_addr           = item.cur_sp;
                  result.mem_data           = item.cur_pc[BYTE_W-1:0];
                  result.new_pc             = vector_of(cur_state.active_source);
                  result.pc_load            = 1'b1;
                  result.halt_clear         = 1'b1;
                  next_state.request_flags  = cur_state.request_flags &
                                              ~cur_state.active_source;
                  next_state.master_enable  = 1'b0;
                  next_state.active_source  = '0;
               end
            end
         end
         KIND_REQUEST: begin
            next_state.request_flags = cur_state.request_flags | item.value;
         end
         KIND_WR_ENABLE: begin
            next_state.enable_mask = item.value;
         end
         KIND_WR_FLAGS: begin
            next_state.request_flags = item.value;
         end
         KIND_WR_MASTER: begin
            next_state.master_enable = item.value[0];
         end
         default: begin
         end
      endcase

      result.ime_out   = next_state.master_enable;
      result.flags_out = next_state.request_flags;
      result.busy_res  = (next_state.steps_left != '0);
   end

endmodule

[src/interrupt_dispatch_controller_unit.sv]
`timescale 1ns / 1ps
// A transaction is registered in in_item_ff and its result in rsp_item_ff.
// One transaction per cycle unless rsp_chan stalls; a tick advances the dispatch
// by one step. The rate is set by the single controller state update per cycle.
// Reset (synchronous, active high) clears the request flags, enable mask,
// master enable, active source, step count and empties both pipeline registers.

`include "interrupt_dispatch_controller_unit_defines.svh"

module interrupt_dispatch_controller_unit
   import idc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   idc_req_if.sink   req_chan,
   idc_rsp_if.source rsp_chan
);

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_item_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_item_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   step_result;
   logic      advance;
   logic      req_take;
   req_type   req_item;

   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_item.kind   = req_chan.kind;
   assign req_item.value  = req_chan.value;
   assign req_item.cur_pc = req_chan.cur_pc;
   assign req_item.cur_sp = req_chan.cur_sp;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   idc_step u_step (
      .cur_state  (state_ff),
      .item       (in_item_ff),
      .next_state (state_in),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.mem_write  = rsp_item_ff.mem_write;
   assign rsp_chan.mem_addr   = rsp_item_ff.mem_addr;
   assign rsp_chan.mem_data   = rsp_item_ff.mem_data;
   assign rsp_chan.new_sp     = rsp_item_ff.new_sp;
   assign rsp_chan.pc_load    = rsp_item_ff.pc_load;
   assign rsp_chan.new_pc     = rsp_item_ff.new_pc;
   assign rsp_chan.halt_clear = rsp_item_ff.halt_clear;
   assign rsp_chan.ime_out    = rsp_item_ff.ime_out;
   assign rsp_chan.flags_out  = rsp_item_ff.flags_out;
   assign rsp_chan.busy_res   = rsp_item_ff.busy_res;

   // A jump always leaves the master enable cleared and the dispatch finished.
   `IDC_ASSERT_SAME(a_jump_clears_ime, clock, reset,
      rsp_valid_ff && rsp_item_ff.pc_load,
      !rsp_item_ff.ime_out && !rsp_item_ff.busy_res && rsp_item_ff.halt_clear,
      "Jump result with master enable still set or dispatch still running")
   `IDC_ASSERT_SAME(a_active_onehot, clock, reset, 1'b1,
      $onehot0(state_ff.active_source) && state_ff.steps_left <= DISPATCH_STEPS,
      "Active source is not one-hot or step count out of range")
   `IDC_ASSERT_NEXT(a_steps_hold, clock, reset,
      !advance,
      $stable(state_ff),
      "Controller state changed without a transaction being processed")
   `IDC_ASSERT_SAME(a_no_write_idle, clock, reset,
      rsp_valid_ff && !rsp_item_ff.mem_write,
      rsp_item_ff.mem_addr == '0 && rsp_item_ff.mem_data == '0,
      "Stack address or data driven without a write")

endmodule
